[rtl/core/bgr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, codes and reset values of the button gesture recognizer.
// ----------------------------------------------------------------------------
package bgr_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int OP_W    = 2;
    localparam int GEST_W  = 3;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 3;

    // item kinds
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESS   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // gesture codes
    localparam logic [GEST_W-1:0] G_CLICK      = 3'd0;
    localparam logic [GEST_W-1:0] G_DOUBLE     = 3'd1;
    localparam logic [GEST_W-1:0] G_LONG_START = 3'd2;
    localparam logic [GEST_W-1:0] G_LONG_END   = 3'd3;
    localparam logic [GEST_W-1:0] G_REPEAT     = 3'd4;

    // button modes
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PENDING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LONG    = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_CLICK_MAX   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_DBL_WINDOW  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_LONG_TIME   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_REPEAT_INT  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_STEP_PERIOD = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_CLICK_MAX   = 16'd400;
    localparam logic [CFG_W-1:0] RST_DBL_WINDOW  = 16'd400;
    localparam logic [CFG_W-1:0] RST_LONG_TIME   = 16'd800;
    localparam logic [CFG_W-1:0] RST_REPEAT_INT  = 16'd100;
    localparam logic [CFG_W-1:0] RST_STEP_PERIOD = 16'd20;

    typedef struct packed {
        logic [CFG_W-1:0] click_max_time;
        logic [CFG_W-1:0] double_click_window;
        logic [CFG_W-1:0] long_press_time;
        logic [CFG_W-1:0] repeat_interval;
        logic [CFG_W-1:0] step_period;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [GEST_W-1:0] gesture;
        logic [TIME_W-1:0] stamp_ms;
        logic [TIME_W-1:0] hold_ms;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/bgr_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_cfg
// Timing setting registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bgr_cfg (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire  [bgr_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire  [bgr_pkg::CFG_W-1:0]   i_cfg_wdata,
    output bgr_pkg::t_cfg               o_cfg
);
    import bgr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_max_time      <= RST_CLICK_MAX;
            r_cfg.double_click_window <= RST_DBL_WINDOW;
            r_cfg.long_press_time     <= RST_LONG_TIME;
            r_cfg.repeat_interval     <= RST_REPEAT_INT;
            r_cfg.step_period         <= RST_STEP_PERIOD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CLICK_MAX:   r_cfg.click_max_time      <= i_cfg_wdata;
                CFG_DBL_WINDOW:  r_cfg.double_click_window <= i_cfg_wdata;
                CFG_LONG_TIME:   r_cfg.long_press_time     <= i_cfg_wdata;
                CFG_REPEAT_INT:  r_cfg.repeat_interval     <= i_cfg_wdata;
                CFG_STEP_PERIOD: r_cfg.step_period         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/core/bgr_fsm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_fsm
// Button mode and stored times; decides the gesture for the registered word.
// ----------------------------------------------------------------------------
module bgr_fsm (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_adv,
    input  wire  [bgr_pkg::OP_W-1:0]    i_op,
    input  wire  [bgr_pkg::TIME_W-1:0]  i_time,
    input  bgr_pkg::t_cfg               i_cfg,
    output bgr_pkg::t_result            o_res
);
    import bgr_pkg::*;

    logic [MODE_W-1:0] r_mode,         n_mode;
    logic [TIME_W-1:0] r_press_time,   n_press_time;
    logic [TIME_W-1:0] r_release_time, n_release_time;
    logic [TIME_W-1:0] r_repeat_time,  n_repeat_time;
    logic [TIME_W-1:0] r_step_time,    n_step_time;

    logic [TIME_W-1:0] d_step, d_press, d_release, d_repeat;
    t_result           res;

    // all differences wrap modulo 2^32
    assign d_step    = i_time - r_step_time;
    assign d_press   = i_time - r_press_time;
    assign d_release = i_time - r_release_time;
    assign d_repeat  = i_time - r_repeat_time;

    always_comb begin
        n_mode         = r_mode;
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        n_repeat_time  = r_repeat_time;
        n_step_time    = r_step_time;
        res.valid      = 1'b0;
        res.gesture    = G_CLICK;
        res.stamp_ms   = i_time;
        res.hold_ms    = '0;
        unique case (i_op)
            OP_TICK: begin
                if (d_step >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.step_period}) begin
                    n_step_time = i_time;
                    unique case (r_mode)
                        MODE_PENDING: begin
                            if (d_press >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_time}) begin
                                res.valid     = 1'b1;
                                res.gesture   = G_LONG_START;
                                n_repeat_time = i_time;
                                n_mode        = MODE_LONG;
                            end
                        end
                        MODE_WAIT: begin
                            if (d_release >
                                {{(TIME_W-CFG_W){1'b0}}, i_cfg.double_click_window}) begin
                                res.valid   = 1'b1;
                                res.gesture = G_CLICK;
                                n_mode      = MODE_IDLE;
                            end
                        end
                        MODE_LONG: begin
                            if (d_repeat >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.repeat_interval}) begin
                                res.valid     = 1'b1;
                                res.gesture   = G_REPEAT;
                                res.hold_ms   = d_press;
                                n_repeat_time = i_time;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_PRESS: begin
                if (r_mode == MODE_IDLE) begin
                    n_press_time = i_time;
                    n_mode       = MODE_PENDING;
                end else if (r_mode == MODE_WAIT) begin
                    // a late second press drops the click
                    if (d_release <= {{(TIME_W-CFG_W){1'b0}}, i_cfg.double_click_window}) begin
                        res.valid   = 1'b1;
                        res.gesture = G_DOUBLE;
                    end
                    n_mode = MODE_IDLE;
                end
            end
            OP_RELEASE: begin
                if (r_mode == MODE_PENDING) begin
                    if (d_press <= {{(TIME_W-CFG_W){1'b0}}, i_cfg.click_max_time}) begin
                        n_release_time = i_time;
                        n_mode         = MODE_WAIT;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end else if (r_mode == MODE_LONG) begin
                    res.valid   = 1'b1;
                    res.gesture = G_LONG_END;
                    res.hold_ms = d_press;
                    n_mode      = MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_press_time   <= '0;
            r_release_time <= '0;
            r_repeat_time  <= '0;
            r_step_time    <= '0;
        end else if (i_adv) begin
            r_mode         <= n_mode;
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
            r_repeat_time  <= n_repeat_time;
            r_step_time    <= n_step_time;
        end
    end

    assign o_res = res;

    a_long_start_enters_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.valid && res.gesture == G_LONG_START) |=> (r_mode == MODE_LONG))
        else $error("long start without entering long mode");

    a_end_or_double_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.valid && (res.gesture == G_LONG_END || res.gesture == G_DOUBLE))
        |=> (r_mode == MODE_IDLE))
        else $error("mode not idle after long end or double click");

    a_hold_state_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_mode) && $stable(r_step_time) && $stable(r_press_time)))
        else $error("state moved without an advancing word");

    a_step_time_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_op != OP_TICK) |=> $stable(r_step_time))
        else $error("step time changed on a button event");

endmodule
`default_nettype wire

[rtl/core/button_gesture_recognizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_gesture_recognizer
// Turns press, release and tick words into click, double click, long start,
// repeat and long end gestures.
//
// Input stream: tuser carries the kind (tick, press, release), tdata the
// millisecond timestamp. Output stream: tuser carries the gesture code,
// tdata the gesture timestamp and the hold time. Timing settings are to be
// written by the user through the plain write port only while no word is in
// flight; the block itself does not enforce this. An accepted word passes
// through the input register and then the result register, which offers
// its result to the output. Throughput: one word per cycle while the receiver
// does not stall; each word is decided in a single pass against the stored
// mode and times. Words that cause no gesture leave no output word.
// Reset clears the mode, stored times and both stages, and loads the default
// settings. When the receiver stalls, the result register holds and the
// input register keeps taking one more word; after that tready drops until
// the result is taken.
// ----------------------------------------------------------------------------
module button_gesture_recognizer (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input stream
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [bgr_pkg::TIME_W-1:0]        i_s_axis_tdata,  // [31:0] time_ms
    input  wire  [bgr_pkg::OP_W-1:0]          i_s_axis_tuser,  // [1:0] op
    // output stream
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [2*bgr_pkg::TIME_W-1:0]      o_m_axis_tdata,  // [31:0] stamp_ms, [63:32] hold_ms
    output logic [bgr_pkg::GEST_W-1:0]        o_m_axis_tuser,  // [2:0] gesture
    // settings write port
    input  wire                               i_cfg_wr_en,
    input  wire  [bgr_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire  [bgr_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import bgr_pkg::*;

    t_cfg              cfg;
    t_result           res;
    logic              adv;

    logic              r_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [TIME_W-1:0] r_in_time;

    logic              r_out_valid;
    logic [GEST_W-1:0] r_out_gesture;
    logic [TIME_W-1:0] r_out_stamp;
    logic [TIME_W-1:0] r_out_hold;

    bgr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bgr_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_op    (r_in_op),
        .i_time  (r_in_time),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // registered word moves on once the result slot is free or being emptied
    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_time <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid) begin
            r_out_gesture <= res.gesture;
            r_out_stamp   <= res.stamp_ms;
            r_out_hold    <= res.hold_ms;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_hold, r_out_stamp};
    assign o_m_axis_tuser  = r_out_gesture;

endmodule
`default_nettype wire
